>>> design/psep_pkg.sv
package psep_pkg;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic               fixed;
    logic               moving;
  } particle_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_DIFF,
    ST_SQ,
    ST_ROOT_GO,
    ST_ROOT,
    ST_MULP,
    ST_DIV_GO,
    ST_DIV,
    ST_PUSH,
    ST_CROSS,
    ST_NUDGE,
    ST_WR_A,
    ST_WR_B,
    ST_OUT
  } state_t;

  localparam logic [30:0] RADIUS_RESET = 31'd134349;

  // Clamp a widened sum back into the signed 32-bit range.
  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -34'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> design/particle_pair_separation.sv
// Channel   | Handshake             | Payload
// ----------+-----------------------+------------------------------------------------
// request   | start / busy          | pos_x pos_y prev_x prev_y fixed_flag
//           |                       | moving_flag last_particle
// result    | result_valid (strobe) | particle_index new_x new_y last_result overflowed
// config    | contact_radius_we     | contact_radius_wdata
//
// A load is taken whenever busy is low, and busy stays low between loads. The request
// that carries last_particle starts the pair pass. Each pair i<j ends at the distance
// check when the coordinate distance already rules it out, or after the 32-step square
// root when that rejects it. A colliding pair runs the root and the 32-step divider in
// series, with the sideways nudge where needed, and then the writes of both particles
// follow, in ST_WR_A and ST_WR_B, on the single write port of the particle memory.
// Results then stream out one per cycle from the memory's first read port.
// Reset is synchronous and active high; it clears the control state and sets
// the radius to 2.05. The receiver cannot stall; results are strobed once.
module particle_pair_separation import psep_pkg::*; #(
  parameter int MAX_PARTICLES = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] prev_x,
  input  logic signed [31:0] prev_y,
  input  logic               fixed_flag,
  input  logic               moving_flag,
  input  logic               last_particle,
  input  logic               contact_radius_we,
  input  logic [30:0]        contact_radius_wdata,
  output logic               result_valid,
  output logic [5:0]         particle_index,
  output logic signed [31:0] new_x,
  output logic signed [31:0] new_y,
  output logic               last_result,
  output logic               overflowed
);

  localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int CW = $clog2(MAX_PARTICLES + 1);
  localparam logic [CW-1:0] CAP = CW'(MAX_PARTICLES);

  state_t state, state_next;

  logic [30:0]   radius;
  logic [CW-1:0] count;
  logic          drop_seen;
  logic [CW-1:0] n, i, j, k;

  particle_t          ea, eb;
  logic signed [32:0] dx, dy;
  logic [61:0]        sqx, sqy, prx, pry;
  logic [31:0]        len;
  logic [30:0]        pen;
  logic signed [31:0] sx, sy;
  logic signed [65:0] c1, c2;

  logic          out_pend, out_last, out_ovf;
  logic [AW-1:0] out_idx;

  // Memory and unit control.
  logic          mem_we;
  logic [AW-1:0] mem_waddr, raddr_a;
  particle_t     mem_wdata, rd_a, rd_b;
  logic          sqrt_start, sqrt_done, div_start, divx_done, divy_done;
  logic [31:0]   root, qx, qy;

  // Combinational helpers.
  logic          accept, store_ok, pass_go;
  logic [CW-1:0] count_after;
  logic [32:0]   magx, magy;
  logic          near, reject, adv, pairs_done, need_nudge, mover_a, flip;
  particle_t     mover;
  logic signed [32:0] mx, my;
  logic signed [33:0] nx, ny;

  assign accept      = start && !busy;
  assign store_ok    = count < CAP;
  assign count_after = store_ok ? count + CW'(1) : count;
  assign pass_go     = accept && last_particle;

  assign magx = dx[32] ? 33'(-dx) : 33'(dx);
  assign magy = dy[32] ? 33'(-dy) : 33'(dy);
  assign near = (magx < {2'b00, radius}) && (magy < {2'b00, radius});

  // A zero length means coincident points, which are skipped.
  assign reject = (root == 32'd0) || (root >= {1'b0, radius});

  assign adv = (state == ST_SQ && !near) || (state == ST_ROOT && sqrt_done && reject) ||
               (state == ST_WR_B);
  assign pairs_done = (j == n - CW'(1)) && (i + CW'(2) >= n);

  assign mover_a    = ea.moving;
  assign need_nudge = ea.moving != eb.moving;
  assign mover      = mover_a ? ea : eb;
  assign mx         = 33'(mover.x) - 33'(mover.px);
  assign my         = 33'(mover.y) - 33'(mover.py);

  // The sideways nudge faces away from the mover's motion.
  assign flip = c1 > c2;
  assign nx   = flip ? 34'(sy) : -34'(sy);
  assign ny   = flip ? -34'(sx) : 34'(sx);

  psep_store #(.DEPTH(MAX_PARTICLES), .AW(AW)) u_store (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (raddr_a),
    .raddr_b (j[AW-1:0]),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  psep_sqrt u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (sqrt_start),
    .operand ({1'b0, 63'(sqx) + 63'(sqy)}),
    .done    (sqrt_done),
    .root    (root)
  );

  psep_div u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (64'(prx) + 64'(len)),
    .divisor  ({len[30:0], 1'b0}),
    .done     (divx_done),
    .quot     (qx)
  );

  psep_div u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (64'(pry) + 64'(len)),
    .divisor  ({len[30:0], 1'b0}),
    .done     (divy_done),
    .quot     (qy)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (pass_go) begin
          state_next = (count_after < CW'(2)) ? ST_OUT : ST_RD;
        end
      end
      ST_RD:      state_next = ST_DIFF;
      ST_DIFF:    state_next = ST_SQ;
      ST_SQ: begin
        if (!near) begin
          state_next = pairs_done ? ST_OUT : ST_RD;
        end else begin
          state_next = ST_ROOT_GO;
        end
      end
      ST_ROOT_GO: state_next = ST_ROOT;
      ST_ROOT: begin
        if (sqrt_done) begin
          if (reject) begin
            state_next = pairs_done ? ST_OUT : ST_RD;
          end else begin
            state_next = ST_MULP;
          end
        end
      end
      ST_MULP:    state_next = ST_DIV_GO;
      ST_DIV_GO:  state_next = ST_DIV;
      ST_DIV: begin
        if (divx_done && divy_done) begin
          state_next = ST_PUSH;
        end
      end
      ST_PUSH:    state_next = need_nudge ? ST_CROSS : ST_WR_A;
      ST_CROSS:   state_next = ST_NUDGE;
      ST_NUDGE:   state_next = ST_WR_A;
      ST_WR_A:    state_next = ST_WR_B;
      ST_WR_B:    state_next = pairs_done ? ST_OUT : ST_RD;
      ST_OUT: begin
        if (k == n - CW'(1)) begin
          state_next = ST_IDLE;
        end
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: memory port and unit control.
  always_comb begin
    busy       = 1'b1;
    mem_we     = 1'b0;
    mem_waddr  = count[AW-1:0];
    mem_wdata  = '{x: pos_x, y: pos_y, px: prev_x, py: prev_y,
                   fixed: fixed_flag, moving: moving_flag};
    raddr_a    = i[AW-1:0];
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        busy   = 1'b0;
        mem_we = accept && store_ok;
      end
      ST_ROOT_GO: sqrt_start = 1'b1;
      ST_DIV_GO:  div_start  = 1'b1;
      ST_WR_A: begin
        mem_we    = 1'b1;
        mem_waddr = i[AW-1:0];
        mem_wdata = ea;
      end
      ST_WR_B: begin
        mem_we    = 1'b1;
        mem_waddr = j[AW-1:0];
        mem_wdata = eb;
      end
      ST_OUT:  raddr_a = k[AW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      radius    <= RADIUS_RESET;
      count     <= '0;
      drop_seen <= 1'b0;
      out_pend  <= 1'b0;
    end else begin
      state    <= state_next;
      out_pend <= (state == ST_OUT);
      if (contact_radius_we) begin
        radius <= contact_radius_wdata;
      end
      if (state == ST_IDLE && accept) begin
        count <= count_after;
        if (!store_ok) begin
          drop_seen <= 1'b1;
        end
      end
      if (state == ST_OUT && k == n - CW'(1)) begin
        count     <= '0;
        drop_seen <= 1'b0;
      end
    end
  end

  // Pair datapath.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (pass_go) begin
          n       <= count_after;
          i       <= '0;
          j       <= CW'(1);
          k       <= '0;
          out_ovf <= drop_seen || !store_ok;
        end
      end
      ST_DIFF: begin
        ea <= rd_a;
        eb <= rd_b;
        dx <= 33'(rd_b.x) - 33'(rd_a.x);
        dy <= 33'(rd_b.y) - 33'(rd_a.y);
      end
      ST_SQ: begin
        sqx <= 62'(magx[30:0]) * 62'(magx[30:0]);
        sqy <= 62'(magy[30:0]) * 62'(magy[30:0]);
      end
      ST_ROOT: begin
        len <= root;
        pen <= radius - root[30:0];
      end
      ST_MULP: begin
        prx <= 62'(magx[30:0]) * 62'(pen);
        pry <= 62'(magy[30:0]) * 62'(pen);
      end
      ST_DIV: begin
        sx <= dx[32] ? -$signed(qx) : $signed(qx);
        sy <= dy[32] ? -$signed(qy) : $signed(qy);
      end
      ST_PUSH: begin
        if (!ea.fixed) begin
          ea.x <= sat34(34'(ea.x) - 34'(sx));
          ea.y <= sat34(34'(ea.y) - 34'(sy));
        end
        if (!eb.fixed) begin
          eb.x <= sat34(34'(eb.x) + 34'(sx));
          eb.y <= sat34(34'(eb.y) + 34'(sy));
        end
      end
      ST_CROSS: begin
        c1 <= 66'(dx) * 66'(my);
        c2 <= 66'(dy) * 66'(mx);
      end
      ST_NUDGE: begin
        // The nudge reaches the other particle even when it is immovable.
        if (mover_a) begin
          eb.x <= sat34(34'(eb.x) + nx);
          eb.y <= sat34(34'(eb.y) + ny);
        end else begin
          ea.x <= sat34(34'(ea.x) + nx);
          ea.y <= sat34(34'(ea.y) + ny);
        end
      end
      ST_OUT: begin
        out_idx  <= k[AW-1:0];
        out_last <= (k == n - CW'(1));
        k        <= k + CW'(1);
      end
      default: ;
    endcase
    if (adv) begin
      if (j == n - CW'(1)) begin
        i <= i + CW'(1);
        j <= i + CW'(2);
      end else begin
        j <= j + CW'(1);
      end
    end
  end

  assign result_valid   = out_pend;
  assign particle_index = 6'(out_idx);
  assign new_x          = rd_a.x;
  assign new_y          = rd_a.y;
  assign last_result    = out_last;
  assign overflowed     = out_ovf;

endmodule

>>> design/psep_store.sv
module psep_store import psep_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  particle_t     wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output particle_t     rdata_a,
  output particle_t     rdata_b
);

  particle_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> design/psep_sqrt.sv
module psep_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] operand,
  output logic        done,
  output logic [31:0] root
);

  logic        running;
  logic [4:0]  cnt;
  logic [63:0] op;
  logic [33:0] rem;
  logic [35:0] trial_in;
  logic [35:0] trial;
  logic        take;

  // One result bit per cycle, two operand bits brought down each step.
  assign trial_in = {rem, op[63:62]};
  assign trial    = {2'b00, root, 2'b01};
  assign take     = trial_in >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op   <= operand;
      rem  <= '0;
      root <= '0;
    end else if (running) begin
      op   <= {op[61:0], 2'b00};
      rem  <= take ? 34'(trial_in - trial) : trial_in[33:0];
      root <= {root[30:0], take};
    end
  end

endmodule

>>> design/psep_div.sv
module psep_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quot
);

  // The quotient is known to fit in 32 bits, so the upper dividend half
  // seeds the remainder and only 32 steps remain.
  logic        running;
  logic [4:0]  cnt;
  logic [31:0] rem;
  logic [31:0] low;
  logic [31:0] dv;
  logic [32:0] t;
  logic        take;

  assign t    = {rem, low[31]};
  assign take = t >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= dividend[63:32];
      low  <= dividend[31:0];
      dv   <= divisor;
      quot <= '0;
    end else if (running) begin
      rem  <= take ? 32'(t - {1'b0, dv}) : t[31:0];
      low  <= {low[30:0], 1'b0};
      quot <= {quot[30:0], take};
    end
  end

endmodule
